// ===== design/tam_pkg.sv =====
package tam_pkg;

   localparam int HEIGHT_BITS     = 24;
   localparam int ANGLE_FRAC_BITS = 6;
   localparam int SPAN_W          = 2;
   localparam int CELL_W          = 24;
   localparam int CSR_W           = 24;
   localparam int CSR_IDX_W       = 3;

   localparam int DIFF_W  = HEIGHT_BITS + 1;
   localparam int MAG_W   = HEIGHT_BITS;
   localparam int SMAG_W  = MAG_W + SPAN_W;
   localparam int PROD_W  = SMAG_W + CELL_W;
   localparam int SHIFT_W = $clog2(PROD_W);
   localparam int NORM_W  = 30;
   localparam int CX_W    = NORM_W + 4;
   localparam int CZ_W    = 24;
   localparam int CORDIC_STEPS = 20;
   localparam int Z_SHIFT = 14 - ANGLE_FRAC_BITS;

   localparam int TURN_FULL    = 360 * (2 ** ANGLE_FRAC_BITS);
   localparam int TURN_HALF    = 180 * (2 ** ANGLE_FRAC_BITS);
   localparam int TURN_QUARTER = 90 * (2 ** ANGLE_FRAC_BITS);
   localparam int AZ_W   = 15;
   localparam int RNG_W  = 14;
   localparam int ANG_W  = $clog2(TURN_FULL + 1);
   localparam int PHI_W  = $clog2(TURN_QUARTER + 1);
   localparam int SANG_W = ANG_W + 2;

   localparam int MASK_W  = 17;
   localparam int T_W     = 16;
   localparam int REM_W   = RNG_W + 1;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES = T_W / DIV_BITS_PER_STAGE;
   localparam int TT_W    = 2 * T_W;
   localparam int K_W     = T_W + 2;
   localparam int SM_W    = TT_W + K_W;
   localparam int ONE_Q16 = 65536;

   localparam logic [CSR_IDX_W-1:0] REG_AZIMUTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_MIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_MAX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FALLOFF   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CELL_X    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CELL_Y    = 3'd5;

   typedef enum logic [1:0] {
      MODE_ZERO,
      MODE_ONE,
      MODE_RISE,
      MODE_FALL
   } mode_type;

   typedef struct packed {
      logic signed [HEIGHT_BITS-1:0] height_left;
      logic signed [HEIGHT_BITS-1:0] height_right;
      logic signed [HEIGHT_BITS-1:0] height_down;
      logic signed [HEIGHT_BITS-1:0] height_up;
      logic [SPAN_W-1:0]             span_x;
      logic [SPAN_W-1:0]             span_y;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic              flat;
   } rsp_type;

   typedef struct packed {
      logic [ANG_W-1:0]  az;
      logic [RNG_W-1:0]  lo;
      logic [RNG_W-1:0]  hi;
      logic [RNG_W-1:0]  fall;
      logic [CELL_W-1:0] cx;
      logic [CELL_W-1:0] cy;
   } cfg_type;

   typedef struct packed {
      logic flat;
      logic u_neg;
      logic v_neg;
   } side_type;

   typedef struct packed {
      side_type          side;
      logic [NORM_W-1:0] a;
      logic [NORM_W-1:0] b;
   } vec_type;

   typedef struct packed {
      side_type               side;
      logic signed [CZ_W-1:0] z;
   } ang_type;

   typedef struct packed {
      logic            flat;
      mode_type        mode;
      logic [SM_W-1:0] prod;
   } wgt_type;

   function automatic logic signed [CZ_W-1:0] atan_step(input int i);
      logic signed [CZ_W-1:0] r;
      case (i)
         0: r = 24'sd737280;
         1: r = 24'sd435242;
         2: r = 24'sd229970;
         3: r = 24'sd116736;
         4: r = 24'sd58595;
         5: r = 24'sd29326;
         6: r = 24'sd14667;
         7: r = 24'sd7334;
         8: r = 24'sd3667;
         9: r = 24'sd1833;
         10: r = 24'sd917;
         11: r = 24'sd458;
         12: r = 24'sd229;
         13: r = 24'sd115;
         14: r = 24'sd57;
         15: r = 24'sd29;
         16: r = 24'sd14;
         17: r = 24'sd7;
         18: r = 24'sd4;
         19: r = 24'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== design/tam_grad.sv =====
module tam_grad (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  tam_pkg::req_type  in_data,
   input  tam_pkg::cfg_type  cfg,
   output logic              out_valid,
   output tam_pkg::vec_type  out_data
);

   localparam int DW = tam_pkg::DIFF_W;
   localparam int SW = tam_pkg::SMAG_W;
   localparam int PW = tam_pkg::PROD_W;
   localparam int NW = tam_pkg::NORM_W;

   logic [4:0] valid_ff;

   logic signed [DW-1:0] dx_ff, dy_ff;
   logic [tam_pkg::SPAN_W-1:0] sx_ff, sy_ff;

   logic [DW-1:0] magx, magy;
   logic [SW-1:0] mx_ff, my_ff;
   tam_pkg::side_type side2_ff, side3_ff, side4_ff;

   logic [PW-1:0] a_ff, b_ff, a4_ff, b4_ff;
   logic [PW-1:0] m;
   logic [tam_pkg::SHIFT_W-1:0] p_in, p_ff;

   logic [PW+NW-2:0] a_wide, b_wide;
   tam_pkg::vec_type out_ff;

   assign magx = dx_ff[DW-1] ? DW'(-dx_ff) : DW'(dx_ff);
   assign magy = dy_ff[DW-1] ? DW'(-dy_ff) : DW'(dy_ff);

   assign m = a_ff | b_ff;
   always_comb begin
      p_in = '0;
      for (int i = 0; i < PW; i++) begin
         if (m[i]) begin
            p_in = tam_pkg::SHIFT_W'(i);
         end
      end
   end

   assign a_wide = {a4_ff, {(NW-1){1'b0}}} >> p_ff;
   assign b_wide = {b4_ff, {(NW-1){1'b0}}} >> p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
         dx_ff <= DW'(in_data.height_right) - DW'(in_data.height_left);
         dy_ff <= DW'(in_data.height_up) - DW'(in_data.height_down);
         sx_ff <= (in_data.span_x == '0) ? tam_pkg::SPAN_W'(1) : in_data.span_x;
         sy_ff <= (in_data.span_y == '0) ? tam_pkg::SPAN_W'(1) : in_data.span_y;

         mx_ff <= SW'(magx[tam_pkg::MAG_W-1:0]) * SW'(sy_ff);
         my_ff <= SW'(magy[tam_pkg::MAG_W-1:0]) * SW'(sx_ff);
         side2_ff.flat  <= (dx_ff == '0) && (dy_ff == '0);
         side2_ff.u_neg <= !dy_ff[DW-1] && (dy_ff != '0);
         side2_ff.v_neg <= !dx_ff[DW-1] && (dx_ff != '0);

         a_ff <= PW'(my_ff) * PW'(cfg.cx);
         b_ff <= PW'(mx_ff) * PW'(cfg.cy);
         side3_ff <= side2_ff;

         a4_ff <= a_ff;
         b4_ff <= b_ff;
         p_ff <= p_in;
         side4_ff <= side3_ff;

         out_ff.side <= side4_ff;
         out_ff.a <= a_wide[NW-1:0];
         out_ff.b <= b_wide[NW-1:0];
      end
   end

   assign out_valid = valid_ff[4];
   assign out_data = out_ff;

endmodule

// ===== design/tam_cordic.sv =====
module tam_cordic (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  tam_pkg::vec_type  in_data,
   output logic              out_valid,
   output tam_pkg::ang_type  out_data
);

   localparam int N  = tam_pkg::CORDIC_STEPS;
   localparam int XW = tam_pkg::CX_W;
   localparam int ZW = tam_pkg::CZ_W;

   logic [N-1:0] valid_ff;
   logic signed [XW-1:0] x_ff [N];
   logic signed [XW-1:0] y_ff [N];
   logic signed [ZW-1:0] z_ff [N];
   tam_pkg::side_type side_ff [N];

   logic signed [XW-1:0] x_in [N];
   logic signed [XW-1:0] y_in [N];
   logic signed [ZW-1:0] z_in [N];

   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [XW-1:0] xp, yp, dx, dy;
      logic signed [ZW-1:0] zp;
      if (i == 0) begin : g_first
         assign xp = XW'(in_data.a);
         assign yp = XW'(in_data.b);
         assign zp = '0;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
      end
      assign dx = yp >>> i;
      assign dy = xp >>> i;
      always_comb begin
         if (!yp[XW-1]) begin
            x_in[i] = xp + dx;
            y_in[i] = yp - dy;
            z_in[i] = zp + tam_pkg::atan_step(i);
         end else begin
            x_in[i] = xp - dx;
            y_in[i] = yp + dy;
            z_in[i] = zp - tam_pkg::atan_step(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[N-2:0], in_valid};
         side_ff[0] <= in_data.side;
         for (int i = 1; i < N; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         for (int i = 0; i < N; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_data.side = side_ff[N-1];
   assign out_data.z = z_ff[N-1];

endmodule

// ===== design/tam_weight.sv =====
module tam_weight (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  tam_pkg::ang_type  in_data,
   input  tam_pkg::cfg_type  cfg,
   output logic              out_valid,
   output tam_pkg::wgt_type  out_data
);

   localparam int AW = tam_pkg::ANG_W;
   localparam int SA = tam_pkg::SANG_W;
   localparam int RW = tam_pkg::RNG_W;
   localparam int EW = tam_pkg::REM_W;
   localparam int TW = tam_pkg::T_W;
   localparam int DS = tam_pkg::DIV_STAGES;
   localparam int DB = tam_pkg::DIV_BITS_PER_STAGE;
   localparam int QW = tam_pkg::CZ_W;

   logic [3:0] valid_ff;
   tam_pkg::side_type side1_ff, side2_ff;
   logic flat3_ff;

   logic signed [QW-1:0] zc, zr;
   logic [tam_pkg::PHI_W-1:0] phi_in, phi_ff;
   logic [AW-1:0] th_raw, theta_ff;
   logic signed [SA-1:0] diff, diffw;
   logic [AW-1:0] d_ff;

   logic signed [SA-1:0] ds, los, his, fs, lof, hif;
   tam_pkg::mode_type mode_in, mode4_ff;
   logic [RW-1:0] num_in, num4_ff;
   logic flat4_ff;

   logic [DS-1:0] dvalid_ff;
   logic [EW-1:0] rem_ff [DS];
   logic [TW-1:0] q_ff [DS];
   tam_pkg::mode_type dmode_ff [DS];
   logic dflat_ff [DS];
   logic [EW-1:0] rem_in [DS];
   logic [TW-1:0] q_in [DS];

   logic [1:0] mvalid_ff;
   logic [tam_pkg::TT_W-1:0] tt_ff;
   logic [tam_pkg::K_W-1:0] k_ff;
   tam_pkg::mode_type mode5_ff, mode6_ff;
   logic flat5_ff, flat6_ff;
   logic [tam_pkg::SM_W-1:0] prod_ff;

   assign zc = in_data.z[QW-1] ? '0 : in_data.z;
   assign zr = (zc + QW'(2 ** (tam_pkg::Z_SHIFT - 1))) >>> tam_pkg::Z_SHIFT;
   assign phi_in = (zr > QW'(tam_pkg::TURN_QUARTER)) ?
                   tam_pkg::PHI_W'(tam_pkg::TURN_QUARTER) : zr[tam_pkg::PHI_W-1:0];

   always_comb begin
      case ({side1_ff.u_neg, side1_ff.v_neg})
         2'b00: th_raw = AW'(phi_ff);
         2'b10: th_raw = AW'(tam_pkg::TURN_HALF) - AW'(phi_ff);
         2'b11: th_raw = AW'(tam_pkg::TURN_HALF) + AW'(phi_ff);
         default: th_raw = AW'(tam_pkg::TURN_FULL) - AW'(phi_ff);
      endcase
   end

   assign diff = SA'(theta_ff) - SA'(cfg.az);
   assign diffw = diff[SA-1] ? diff + SA'(tam_pkg::TURN_FULL) : diff;

   assign ds  = SA'(d_ff);
   assign los = SA'(cfg.lo);
   assign his = SA'(cfg.hi);
   assign fs  = SA'(cfg.fall);
   assign lof = los - fs;
   assign hif = his + fs;

   always_comb begin
      mode_in = tam_pkg::MODE_ZERO;
      num_in = '0;
      if (ds >= los && ds <= his) begin
         mode_in = tam_pkg::MODE_ONE;
      end else if (fs == '0) begin
         mode_in = tam_pkg::MODE_ZERO;
      end else if (ds < los && ds > lof) begin
         mode_in = tam_pkg::MODE_RISE;
         num_in = RW'(ds - lof);
      end else if (ds > his && ds < hif) begin
         mode_in = tam_pkg::MODE_FALL;
         num_in = RW'(ds - his);
      end
      if (flat3_ff) begin
         mode_in = tam_pkg::MODE_ZERO;
      end
   end

   for (genvar k = 0; k < DS; k++) begin : g_div
      logic [EW-1:0] rp;
      logic [TW-1:0] qp;
      if (k == 0) begin : g_first
         assign rp = EW'(num4_ff);
         assign qp = '0;
      end else begin : g_next
         assign rp = rem_ff[k-1];
         assign qp = q_ff[k-1];
      end
      always_comb begin
         logic [EW-1:0] r;
         logic [TW-1:0] q;
         r = rp;
         q = qp;
         for (int j = 0; j < DB; j++) begin
            r = {r[EW-2:0], 1'b0};
            if (r >= EW'(cfg.fall)) begin
               r = r - EW'(cfg.fall);
               q = {q[TW-2:0], 1'b1};
            end else begin
               q = {q[TW-2:0], 1'b0};
            end
         end
         rem_in[k] = r;
         q_in[k] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dvalid_ff <= '0;
         mvalid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
         dvalid_ff <= {dvalid_ff[DS-2:0], valid_ff[3]};
         mvalid_ff <= {mvalid_ff[0], dvalid_ff[DS-1]};

         phi_ff <= phi_in;
         side1_ff <= in_data.side;

         theta_ff <= (th_raw >= AW'(tam_pkg::TURN_FULL)) ?
                     th_raw - AW'(tam_pkg::TURN_FULL) : th_raw;
         side2_ff <= side1_ff;

         flat3_ff <= side2_ff.flat;
         d_ff <= (diffw > SA'(tam_pkg::TURN_HALF)) ?
                 AW'(SA'(tam_pkg::TURN_FULL) - diffw) : AW'(diffw);

         mode4_ff <= mode_in;
         num4_ff <= num_in;
         flat4_ff <= flat3_ff;

         dmode_ff[0] <= mode4_ff;
         dflat_ff[0] <= flat4_ff;
         for (int k = 1; k < DS; k++) begin
            dmode_ff[k] <= dmode_ff[k-1];
            dflat_ff[k] <= dflat_ff[k-1];
         end
         for (int k = 0; k < DS; k++) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k] <= q_in[k];
         end

         tt_ff <= tam_pkg::TT_W'(q_ff[DS-1]) * tam_pkg::TT_W'(q_ff[DS-1]);
         k_ff <= tam_pkg::K_W'(3 * tam_pkg::ONE_Q16) - {q_ff[DS-1], 1'b0};
         mode5_ff <= dmode_ff[DS-1];
         flat5_ff <= dflat_ff[DS-1];

         prod_ff <= tam_pkg::SM_W'(tt_ff) * tam_pkg::SM_W'(k_ff);
         mode6_ff <= mode5_ff;
         flat6_ff <= flat5_ff;
      end
   end

   assign out_valid = mvalid_ff[1];
   assign out_data.flat = flat6_ff;
   assign out_data.mode = mode6_ff;
   assign out_data.prod = prod_ff;

endmodule

// ===== design/terrain_aspect_mask.sv =====
// Throughput: one item per cycle unless stalled; the gradient, 20-stage
// CORDIC, radix-4 divider and smoothstep multiply stages all advance
// together. A stall on the result side while rsp_valid is high holds
// every stage in place.
// Reset (synchronous): clears all valid bits and loads register defaults.
module terrain_aspect_mask (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tam_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tam_pkg::rsp_type                rsp_data,
   input  logic                            csr_write_en,
   input  logic [tam_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tam_pkg::CSR_W-1:0]       csr_wdata
);

   localparam int RW = tam_pkg::RNG_W;
   localparam int AW = tam_pkg::ANG_W;

   logic [tam_pkg::AZ_W-1:0] azimuth_ff;
   logic [RW-1:0] range_min_ff, range_max_ff, falloff_ff;
   logic [tam_pkg::CELL_W-1:0] cell_x_ff, cell_y_ff;

   tam_pkg::cfg_type cfg;
   logic [RW-1:0] lo_c, hi_c;

   logic en;
   logic g_valid, c_valid, w_valid;
   tam_pkg::vec_type g_data;
   tam_pkg::ang_type c_data;
   tam_pkg::wgt_type w_data;

   logic [tam_pkg::SM_W:0] rnd_sum;
   logic [tam_pkg::MASK_W-1:0] s;
   tam_pkg::rsp_type rsp_in, rsp_data_ff;
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         azimuth_ff <= '0;
         range_min_ff <= '0;
         range_max_ff <= RW'(2880);
         falloff_ff <= RW'(320);
         cell_x_ff <= tam_pkg::CELL_W'(65536);
         cell_y_ff <= tam_pkg::CELL_W'(65536);
      end else if (csr_write_en) begin
         unique case (csr_index)
            tam_pkg::REG_AZIMUTH:   azimuth_ff <= csr_wdata[tam_pkg::AZ_W-1:0];
            tam_pkg::REG_RANGE_MIN: range_min_ff <= csr_wdata[RW-1:0];
            tam_pkg::REG_RANGE_MAX: range_max_ff <= csr_wdata[RW-1:0];
            tam_pkg::REG_FALLOFF:   falloff_ff <= csr_wdata[RW-1:0];
            tam_pkg::REG_CELL_X:    cell_x_ff <= csr_wdata[tam_pkg::CELL_W-1:0];
            tam_pkg::REG_CELL_Y:    cell_y_ff <= csr_wdata[tam_pkg::CELL_W-1:0];
            default: ;
         endcase
      end
   end

   assign lo_c = (range_min_ff > RW'(tam_pkg::TURN_HALF)) ?
                 RW'(tam_pkg::TURN_HALF) : range_min_ff;
   assign hi_c = (range_max_ff > RW'(tam_pkg::TURN_HALF)) ?
                 RW'(tam_pkg::TURN_HALF) : range_max_ff;
   assign cfg.az = (AW'(azimuth_ff) >= AW'(tam_pkg::TURN_FULL)) ?
                   AW'(azimuth_ff) - AW'(tam_pkg::TURN_FULL) : AW'(azimuth_ff);
   assign cfg.lo = lo_c;
   assign cfg.hi = (hi_c < lo_c) ? lo_c : hi_c;
   assign cfg.fall = (falloff_ff > RW'(tam_pkg::TURN_HALF)) ?
                     RW'(tam_pkg::TURN_HALF) : falloff_ff;
   assign cfg.cx = (cell_x_ff == '0) ? tam_pkg::CELL_W'(1) : cell_x_ff;
   assign cfg.cy = (cell_y_ff == '0) ? tam_pkg::CELL_W'(1) : cell_y_ff;

   assign en = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   tam_grad u_grad (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .cfg       (cfg),
      .out_valid (g_valid),
      .out_data  (g_data)
   );

   tam_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g_valid),
      .in_data   (g_data),
      .out_valid (c_valid),
      .out_data  (c_data)
   );

   tam_weight u_weight (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_valid),
      .in_data   (c_data),
      .cfg       (cfg),
      .out_valid (w_valid),
      .out_data  (w_data)
   );

   assign rnd_sum = {1'b0, w_data.prod} + (tam_pkg::SM_W + 1)'(64'h8000_0000);
   assign s = rnd_sum[32 + tam_pkg::MASK_W - 1:32];

   always_comb begin
      rsp_in.flat = w_data.flat;
      case (w_data.mode)
         tam_pkg::MODE_ONE:  rsp_in.mask = tam_pkg::MASK_W'(tam_pkg::ONE_Q16);
         tam_pkg::MODE_RISE: rsp_in.mask = s;
         tam_pkg::MODE_FALL: rsp_in.mask = tam_pkg::MASK_W'(tam_pkg::ONE_Q16) - s;
         default:            rsp_in.mask = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= w_valid;
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ===== verif/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 40;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 1800;
   localparam logic [tam_pkg::CSR_IDX_W-1:0] REG_SPARE = 3'd7;
   localparam longint ATAN_DEG16K [tam_pkg::CORDIC_STEPS] = '{
      737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29, 14, 7, 4, 2
   };

   typedef struct {
      tam_pkg::req_type stim;
      bit               known;
      tam_pkg::rsp_type want;
   } cell_row_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   tam_pkg::req_type              req_data;
   logic                          rsp_valid;
   logic                          rsp_stall;
   tam_pkg::rsp_type              rsp_data;
   logic                          csr_write_en;
   logic [tam_pkg::CSR_IDX_W-1:0] csr_index;
   logic [tam_pkg::CSR_W-1:0]     csr_wdata;

   longint unsigned azimuth_q, range_lo_q, range_hi_q, falloff_q, cell_x_q, cell_y_q;
   tam_pkg::rsp_type weight_queue[$];
   int              error_count;
   int              sent_count;
   int              result_count;
   int              flat_count;
   int              full_count;
   int              ramp_count;
   int              quiet_cycles;
   int              send_idle_pct;
   int              recv_stall_pct;

   terrain_aspect_mask DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic longint quadrant_angle(longint unsigned a, longint unsigned b);
      longint unsigned m;
      longint          x, y, z, dx, dy, q;
      m = a | b;
      if (m == 0) return 0;
      while (m >= (64'd1 << 30)) begin
         a = a >> 1; b = b >> 1; m = m >> 1;
      end
      while (m < (64'd1 << 29)) begin
         a = a << 1; b = b << 1; m = m << 1;
      end
      x = a;
      y = b;
      z = 0;
      for (int i = 0; i < tam_pkg::CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += ATAN_DEG16K[i];
         end else begin
            x -= dx; y += dy; z -= ATAN_DEG16K[i];
         end
      end
      if (z < 0) z = 0;
      q = (z + (64'sd1 << (tam_pkg::Z_SHIFT - 1))) >>> tam_pkg::Z_SHIFT;
      if (q > tam_pkg::TURN_QUARTER) q = tam_pkg::TURN_QUARTER;
      return q;
   endfunction

   function automatic longint smooth_ramp(longint num, longint den);
      longint t, s;
      t = (num << 16) / den;
      s = t * t * (3 * tam_pkg::ONE_Q16 - 2 * t);
      return (s + (64'sd1 << 31)) >>> 32;
   endfunction

   function automatic tam_pkg::rsp_type predict_weight(tam_pkg::req_type c);
      tam_pkg::rsp_type r;
      longint  dxh, dyh, sx, sy, cx, cy, u, v, phi, theta, az, d, lo, hi, f, w;
      longint unsigned a, b;
      dxh = longint'(c.height_right) - longint'(c.height_left);
      dyh = longint'(c.height_up) - longint'(c.height_down);
      r.flat = 1'b0;
      r.mask = '0;
      if (dxh == 0 && dyh == 0) begin
         r.flat = 1'b1;
         return r;
      end
      sx = (c.span_x == 0) ? 1 : c.span_x;
      sy = (c.span_y == 0) ? 1 : c.span_y;
      cx = (cell_x_q == 0) ? 1 : cell_x_q;
      cy = (cell_y_q == 0) ? 1 : cell_y_q;
      v = -(dxh * sy * cy);
      u = -(dyh * sx * cx);
      a = (u < 0) ? -u : u;
      b = (v < 0) ? -v : v;
      phi = quadrant_angle(a, b);
      if (u >= 0 && v >= 0) theta = phi;
      else if (u < 0 && v >= 0) theta = tam_pkg::TURN_HALF - phi;
      else if (u < 0) theta = tam_pkg::TURN_HALF + phi;
      else theta = tam_pkg::TURN_FULL - phi;
      if (theta >= tam_pkg::TURN_FULL) theta -= tam_pkg::TURN_FULL;
      az = azimuth_q % tam_pkg::TURN_FULL;
      d = (theta + tam_pkg::TURN_FULL - az) % tam_pkg::TURN_FULL;
      if (d > tam_pkg::TURN_HALF) d = tam_pkg::TURN_FULL - d;
      lo = (range_lo_q > tam_pkg::TURN_HALF) ? tam_pkg::TURN_HALF : range_lo_q;
      hi = (range_hi_q > tam_pkg::TURN_HALF) ? tam_pkg::TURN_HALF : range_hi_q;
      if (hi < lo) hi = lo;
      f = (falloff_q > tam_pkg::TURN_HALF) ? tam_pkg::TURN_HALF : falloff_q;
      if (d >= lo && d <= hi) w = tam_pkg::ONE_Q16;
      else if (f == 0) w = 0;
      else if (d < lo && d > lo - f) w = smooth_ramp(d - (lo - f), f);
      else if (d > hi && d < hi + f) w = tam_pkg::ONE_Q16 - smooth_ramp(d - hi, f);
      else w = 0;
      r.mask = w[tam_pkg::MASK_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (weight_queue.size() == 0) begin
               report_mismatch("unexpected item", 1, 0);
            end else begin
               tam_pkg::rsp_type want;
               want = weight_queue.pop_front();
               if (rsp_data.mask !== want.mask) report_mismatch("mask", rsp_data.mask, want.mask);
               if (rsp_data.flat !== want.flat) report_mismatch("flat", rsp_data.flat, want.flat);
               if (want.flat) flat_count++;
               else if (want.mask == tam_pkg::ONE_Q16) full_count++;
               else if (want.mask != 0) ramp_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   task automatic send_cell(tam_pkg::req_type c, bit known, tam_pkg::rsp_type want);
      tam_pkg::rsp_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      pred = predict_weight(c);
      if (known) begin
         if (pred.mask !== want.mask) report_mismatch("table mask", pred.mask, want.mask);
         if (pred.flat !== want.flat) report_mismatch("table flat", pred.flat, want.flat);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      do @(posedge clock); while (req_stall);
      weight_queue.push_back(pred);
      sent_count++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (weight_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic load_config(longint unsigned az, longint unsigned lo, longint unsigned hi,
                              longint unsigned f, longint unsigned cx, longint unsigned cy);
      logic [tam_pkg::CSR_W-1:0] vals [6];
      logic [tam_pkg::CSR_IDX_W-1:0] idx [6];
      vals = '{tam_pkg::CSR_W'(az), tam_pkg::CSR_W'(lo), tam_pkg::CSR_W'(hi),
               tam_pkg::CSR_W'(f), tam_pkg::CSR_W'(cx), tam_pkg::CSR_W'(cy)};
      idx  = '{tam_pkg::REG_AZIMUTH, tam_pkg::REG_RANGE_MIN, tam_pkg::REG_RANGE_MAX,
               tam_pkg::REG_FALLOFF, tam_pkg::REG_CELL_X, tam_pkg::REG_CELL_Y};
      csr_write_en <= 1'b1;
      for (int i = 0; i < 6; i++) begin
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_index <= REG_SPARE;
      csr_wdata <= tam_pkg::CSR_W'($urandom);
      @(posedge clock);
      csr_write_en <= 1'b0;
      azimuth_q  = vals[0] & 24'h7FFF;
      range_lo_q = vals[1] & 24'h3FFF;
      range_hi_q = vals[2] & 24'h3FFF;
      falloff_q  = vals[3] & 24'h3FFF;
      cell_x_q   = vals[4];
      cell_y_q   = vals[5];
      @(posedge clock);
   endtask

   function automatic tam_pkg::req_type make_cell(longint hl, longint hr, longint hd,
                                                  longint hu, int sx, int sy);
      tam_pkg::req_type c;
      c.height_left  = hl[tam_pkg::HEIGHT_BITS-1:0];
      c.height_right = hr[tam_pkg::HEIGHT_BITS-1:0];
      c.height_down  = hd[tam_pkg::HEIGHT_BITS-1:0];
      c.height_up    = hu[tam_pkg::HEIGHT_BITS-1:0];
      c.span_x       = sx[tam_pkg::SPAN_W-1:0];
      c.span_y       = sy[tam_pkg::SPAN_W-1:0];
      return c;
   endfunction

   function automatic tam_pkg::req_type random_cell();
      tam_pkg::req_type c;
      longint  base;
      int      spread;
      c = make_cell($urandom, $urandom, $urandom, $urandom,
                    $urandom_range(3), $urandom_range(3));
      case ($urandom_range(9))
         0, 1, 2, 3, 4: begin
            spread = 1 << $urandom_range(20);
            base = $signed($urandom_range(16000000)) - 8000000;
            c.height_left  = tam_pkg::HEIGHT_BITS'(base + $signed($urandom_range(2 * spread))
                                                   - spread);
            c.height_right = tam_pkg::HEIGHT_BITS'(base + $signed($urandom_range(2 * spread))
                                                   - spread);
            c.height_down  = tam_pkg::HEIGHT_BITS'(base + $signed($urandom_range(2 * spread))
                                                   - spread);
            c.height_up    = tam_pkg::HEIGHT_BITS'(base + $signed($urandom_range(2 * spread))
                                                   - spread);
         end
         5: c.height_right = c.height_left;
         6: c.height_up = c.height_down;
         7: begin
            c.height_right = c.height_left;
            c.height_up    = c.height_down;
         end
         default: ;
      endcase
      return c;
   endfunction

   initial begin
      cell_row_type rows[$];
      cell_row_type row;
      int           phase_items;
      error_count = 0; sent_count = 0; result_count = 0;
      flat_count = 0; full_count = 0; ramp_count = 0;
      send_idle_pct = 31;
      recv_stall_pct = 83;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write_en = 1'b0;
      csr_index = tam_pkg::REG_AZIMUTH;
      csr_wdata = '0;
      azimuth_q = 0; range_lo_q = 0; range_hi_q = 2880; falloff_q = 320;
      cell_x_q = 65536; cell_y_q = 65536;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      row.known = 1'b1;
      row.stim = make_cell(0, 0, 0, 0, 0, 0);               row.want = '{0, 1};
      rows.push_back(row);
      row.stim = make_cell(8388607, 8388607, -8388608, -8388608, 3, 3);
      row.want = '{0, 1};
      rows.push_back(row);
      row.stim = make_cell(0, 0, 100, 0, 1, 1);             row.want = '{tam_pkg::ONE_Q16, 0};
      rows.push_back(row);
      row.stim = make_cell(0, 0, 0, 100, 2, 2);             row.want = '{0, 0};
      rows.push_back(row);
      row.stim = make_cell(-8388608, 8388607, 5, 5, 2, 0);  row.want = '{0, 0};
      rows.push_back(row);
      row.stim = make_cell(8388607, -8388608, 0, 0, 0, 3);  row.want = '{0, 0};
      rows.push_back(row);
      row.stim = make_cell(0, 0, 8388607, -8388608, 3, 0);  row.want = '{tam_pkg::ONE_Q16, 0};
      rows.push_back(row);
      row.known = 1'b0;
      row.want = '0;
      for (int s = 0; s < 16; s++) begin
         row.stim = make_cell(0, (s % 3) - 1, 7, 7 - (s / 4) + 1, s % 4, s / 4);
         rows.push_back(row);
      end
      row.stim = make_cell(-8388608, 8388607, 8388607, -8388608, 3, 3);
      rows.push_back(row);
      row.stim = make_cell(1, 0, 1, 0, 1, 1);
      rows.push_back(row);
      foreach (rows[i]) send_cell(rows[i].stim, rows[i].known, rows[i].want);
      drain();

      load_config(23040, 16383, 0, 0, 0, 16777215);
      foreach (rows[i]) send_cell(rows[i].stim, 1'b0, rows[i].want);
      drain();
      load_config(32767, 11520, 11520, 16383, 16777215, 1);
      foreach (rows[i]) send_cell(rows[i].stim, 1'b0, rows[i].want);
      drain();

      for (int p = 0; p < 9; p++) begin
         if (p == 3) begin
            send_idle_pct = 83; recv_stall_pct = 31;
         end else if (p == 6) begin
            send_idle_pct = 0; recv_stall_pct = 0;
         end
         case (p % 3)
            0: load_config($urandom_range(23040), $urandom_range(2000), $urandom_range(6000),
                           $urandom_range(3000), 1 << $urandom_range(23),
                           1 << $urandom_range(23));
            1: load_config($urandom_range(32767), $urandom_range(16383), $urandom_range(16383),
                           $urandom_range(16383), $urandom_range(16777215),
                           $urandom_range(16777215));
            default: load_config($urandom_range(23040), $urandom_range(1500),
                                 $urandom_range(1500, 4000), $urandom_range(1, 800),
                                 $urandom_range(1, 200000), $urandom_range(1, 200000));
         endcase
         phase_items = RANDOM_ITEMS / 9;
         for (int k = 0; k < phase_items; k++) begin
            send_cell(random_cell(), 1'b0, '0);
            if (p == 4 && k == phase_items / 2) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (weight_queue.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      $display("sent %0d cells over 12 register settings; %0d results:", sent_count,
               result_count);
      $display("%0d flat, %0d full, %0d ramp; mismatches: %0d", flat_count, full_count,
               ramp_count, error_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
design/tam_pkg.sv
design/tam_grad.sv
design/tam_cordic.sv
design/tam_weight.sv
design/terrain_aspect_mask.sv
verif/testbench.sv
